FILE: rtl/core/iterative_dfs_order_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef ITERATIVE_DFS_ORDER_UNIT_DEFINES_SVH
`define ITERATIVE_DFS_ORDER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/idfs_pkg.sv
package idfs_pkg;

    localparam int VERTICES_DEF   = 8;
    localparam int MAX_DEGREE_DEF = 4;

    localparam logic [1:0] MODE_NEIGHBOR = 2'd0;
    localparam logic [1:0] MODE_DEGREE   = 2'd1;
    localparam logic [1:0] MODE_START    = 2'd2;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_TOP   = 4'd1;
    localparam logic [PC_W-1:0] PC_CUR   = 4'd2;
    localparam logic [PC_W-1:0] PC_DEG   = 4'd3;
    localparam logic [PC_W-1:0] PC_SCAN  = 4'd4;
    localparam logic [PC_W-1:0] PC_TEST  = 4'd5;
    localparam logic [PC_W-1:0] PC_VISIT = 4'd6;
    localparam logic [PC_W-1:0] PC_POP   = 4'd7;
    localparam logic [PC_W-1:0] PC_FIN   = 4'd8;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_START,
        C_EMPTY,
        C_SCAN_DONE,
        C_STALE
    } cond_t;

    typedef struct packed {
        logic take;
        logic stk_rd;
        logic ld_cur;
        logic ld_deg;
        logic nb_rd;
        logic slot_inc;
        logic emit;
        logic last;
        logic push;
        logic pop;
    } ctrl_t;

    typedef struct packed {
        ctrl_t           ctl;
        logic            wait_out;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic start;
        logic empty;
        logic scan_done;
        logic stale;
        logic out_busy;
    } status_t;

    function automatic ucode_t microcode(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        w.cond = C_ALWAYS;
        unique case (pc)
            PC_IDLE:
            begin
                w.ctl.take = 1'b1;
                w.cond     = C_NO_START;
                w.target   = PC_IDLE;
            end
            PC_TOP:
            begin
                w.ctl.stk_rd = 1'b1;
                w.cond       = C_EMPTY;
                w.target     = PC_FIN;
            end
            PC_CUR:
            begin
                w.ctl.ld_cur = 1'b1;
                w.target     = PC_DEG;
            end
            PC_DEG:
            begin
                w.ctl.ld_deg = 1'b1;
                w.target     = PC_SCAN;
            end
            PC_SCAN:
            begin
                w.ctl.nb_rd = 1'b1;
                w.cond      = C_SCAN_DONE;
                w.target    = PC_POP;
            end
            PC_TEST:
            begin
                w.ctl.slot_inc = 1'b1;
                w.cond         = C_STALE;
                w.target       = PC_SCAN;
            end
            PC_VISIT:
            begin
                w.ctl.emit = 1'b1;
                w.ctl.push = 1'b1;
                w.wait_out = 1'b1;
                w.target   = PC_TOP;
            end
            PC_POP:
            begin
                w.ctl.pop = 1'b1;
                w.target  = PC_TOP;
            end
            PC_FIN:
            begin
                w.ctl.emit = 1'b1;
                w.ctl.last = 1'b1;
                w.wait_out = 1'b1;
                w.target   = PC_IDLE;
            end
            default:
            begin
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/idfs_sequencer.sv
module idfs_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  idfs_pkg::status_t status,
    output idfs_pkg::ctrl_t   ctrl
);
    import idfs_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          uw;
    logic            hold;
    logic            jump;

    always_comb
    begin
        uw   = microcode(pc_reg);
        hold = uw.wait_out && status.out_busy;
        case (uw.cond)
            C_ALWAYS:    jump = 1'b1;
            C_NO_START:  jump = !status.start;
            C_EMPTY:     jump = status.empty;
            C_SCAN_DONE: jump = status.scan_done;
            C_STALE:     jump = status.stale;
            default:     jump = 1'b1;
        endcase
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (jump)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = PC_W'(pc_reg + 1'b1);
        end
        ctrl = hold ? '0 : uw.ctl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: rtl/core/idfs_datapath.sv
module idfs_datapath #(
    parameter int VERTICES   = idfs_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = idfs_pkg::MAX_DEGREE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  idfs_pkg::ctrl_t   ctrl,
    output idfs_pkg::status_t status,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    input  logic [2:0]        in_vertex,
    input  logic [1:0]        in_slot,
    input  logic [2:0]        in_neighbor,
    input  logic [2:0]        in_degree,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_vertex,
    output logic              out_last
);
    import idfs_pkg::*;

    localparam int VW = $clog2(VERTICES);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int AW = $clog2(VERTICES * MAX_DEGREE);
    localparam int XW = 8;

    logic [2:0]    nb_mem [VERTICES*MAX_DEGREE];
    logic [DW-1:0] deg_mem [VERTICES];
    logic [VW-1:0] stk_mem [VERTICES];

    logic [VERTICES-1:0] deg_vld_reg;
    logic [VERTICES-1:0] vis_reg;
    logic [VW:0]         depth_reg;
    logic                out_valid_reg;

    logic [2:0]    nb_q_reg;
    logic [DW-1:0] deg_q_reg;
    logic          deg_vq_reg;
    logic [VW-1:0] stk_q_reg;
    logic [VW-1:0] cur_reg;
    logic [DW-1:0] slot_reg;
    logic [DW-1:0] deg_reg;
    logic [VW-1:0] pend_reg;
    logic [2:0]    out_vertex_reg;
    logic          out_last_reg;

    logic          accept;
    logic          in_range;
    logic          wr_nb;
    logic          wr_deg;
    logic          start;
    logic [DW-1:0] deg_clamp;
    logic [VW-1:0] v_idx;
    logic [AW-1:0] nb_wr_addr;
    logic [AW-1:0] nb_rd_addr;
    logic [VW-1:0] t_idx;
    logic          t_fresh;
    logic          can_push;
    logic          scan_done;
    logic          stk_we;
    logic [VW-1:0] stk_wa;
    logic [VW-1:0] stk_wd;

    always_comb
    begin
        accept     = in_valid && ctrl.take;
        in_range   = {5'd0, in_vertex} < XW'(VERTICES);
        wr_nb      = accept && in_range && (in_mode == MODE_NEIGHBOR)
                     && ({6'd0, in_slot} < XW'(MAX_DEGREE));
        wr_deg     = accept && in_range && (in_mode == MODE_DEGREE);
        start      = accept && in_range && (in_mode == MODE_START);
        deg_clamp  = ({5'd0, in_degree} > XW'(MAX_DEGREE)) ? DW'(MAX_DEGREE)
                                                            : DW'(in_degree);
        v_idx      = VW'(in_vertex);
        nb_wr_addr = AW'(AW'(v_idx) * AW'(MAX_DEGREE) + AW'(in_slot));
        nb_rd_addr = AW'(AW'(cur_reg) * AW'(MAX_DEGREE) + AW'(slot_reg));
        t_idx      = VW'(nb_q_reg);
        t_fresh    = ({5'd0, nb_q_reg} < XW'(VERTICES)) && !vis_reg[t_idx];
        can_push   = depth_reg < (VW+1)'(VERTICES);
        scan_done  = slot_reg >= deg_reg;
        stk_we     = start || (ctrl.push && can_push);
        stk_wa     = start ? '0 : VW'(depth_reg);
        stk_wd     = start ? v_idx : t_idx;

        status.start     = start;
        status.empty     = depth_reg == '0;
        status.scan_done = scan_done;
        status.stale     = !t_fresh;
        status.out_busy  = out_valid_reg && !out_ready;
    end

    // Hold memories and payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (wr_nb)
        begin
            nb_mem[nb_wr_addr] <= in_neighbor;
        end
        if (wr_deg)
        begin
            deg_mem[v_idx] <= deg_clamp;
        end
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (ctrl.stk_rd)
        begin
            stk_q_reg <= stk_mem[VW'(depth_reg - 1'b1)];
        end
        if (ctrl.ld_cur)
        begin
            deg_q_reg  <= deg_mem[stk_q_reg];
            deg_vq_reg <= deg_vld_reg[stk_q_reg];
            cur_reg    <= stk_q_reg;
            slot_reg   <= '0;
        end
        if (ctrl.ld_deg)
        begin
            deg_reg <= deg_vq_reg ? deg_q_reg : '0;
        end
        if (ctrl.nb_rd && !scan_done)
        begin
            nb_q_reg <= nb_mem[nb_rd_addr];
        end
        if (ctrl.slot_inc)
        begin
            slot_reg <= DW'(slot_reg + 1'b1);
        end
        if (start)
        begin
            pend_reg <= v_idx;
        end
        else if (ctrl.push)
        begin
            pend_reg <= t_idx;
        end
        if (ctrl.emit)
        begin
            out_vertex_reg <= 3'(pend_reg);
            out_last_reg   <= ctrl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_vld_reg   <= '0;
            vis_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_deg)
            begin
                deg_vld_reg[v_idx] <= 1'b1;
            end
            if (start)
            begin
                vis_reg   <= {{(VERTICES-1){1'b0}}, 1'b1} << v_idx;
                depth_reg <= (VW+1)'(1);
            end
            else if (ctrl.push)
            begin
                vis_reg[t_idx] <= 1'b1;
                if (can_push)
                begin
                    depth_reg <= (VW+1)'(depth_reg + 1'b1);
                end
            end
            else if (ctrl.pop)
            begin
                depth_reg <= (VW+1)'(depth_reg - 1'b1);
            end
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_vertex = out_vertex_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: rtl/core/iterative_dfs_order_unit.sv
// Channel   Dir  tdata fields (low bit up)                  tuser / tlast
// s_*       in   vertex[2:0] slot[4:3] neighbor[7:5]        tuser[1:0] = mode
//                degree[10:8], zero fill to 16 bits
// m_*       out  visited_vertex[2:0], zero fill to 8 bits   tlast = last
//
// A load item is taken while idle and leaves the unit ready for the next one.
// A start item runs a microcode program: read the stack top, load that vertex
// and its degree, then scan its neighbor slots past visited or out-of-range
// ones. A fresh neighbor is marked, pushed and the pending vertex emitted; a
// finished scan pops, and an empty stack emits the last vertex and goes idle.
// Reset is asynchronous, active low, and clears degree flags and visited map.
// A stalled result holds the sequencer in its emit step; s_tready is low
// for the whole traversal.
module iterative_dfs_order_unit #(
    parameter int VERTICES   = idfs_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = idfs_pkg::MAX_DEGREE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // vertex, slot, neighbor, degree
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // visited_vertex
    output logic        m_tlast
);
    import idfs_pkg::*;

    ctrl_t      ctrl;
    status_t    status;
    logic [2:0] out_vertex;

    idfs_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    idfs_datapath #(
        .VERTICES   (VERTICES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (s_tvalid),
        .in_mode     (s_tuser),
        .in_vertex   (s_tdata[2:0]),
        .in_slot     (s_tdata[4:3]),
        .in_neighbor (s_tdata[7:5]),
        .in_degree   (s_tdata[10:8]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_vertex  (out_vertex),
        .out_last    (m_tlast)
    );

    assign s_tready = ctrl.take;
    assign m_tdata  = {5'd0, out_vertex};

endmodule

FILE: rtl/core/idfs_checker.sv
`include "iterative_dfs_order_unit_defines.svh"

module idfs_checker #(
    parameter int VERTICES = idfs_pkg::VERTICES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);
    import idfs_pkg::*;

    logic s_xfer;
    logic start_xfer;
    logic m_stall;

    assign s_xfer     = s_tvalid && s_tready;
    assign start_xfer = s_xfer && (s_tuser == MODE_START)
                        && ({4'd0, s_tdata[2:0]} < 7'(VERTICES));
    assign m_stall    = m_tvalid && !m_tready;

    `ASSERT_NEXT(a_out_hold, m_stall, m_tvalid)
    `ASSERT_NEXT(a_out_stable, m_stall, $stable(m_tdata) && $stable(m_tlast))
    `ASSERT_NEXT(a_busy_after_start, start_xfer, !s_tready)
    `ASSERT_NEXT(a_ready_after_load, s_xfer && !start_xfer, s_tready)

endmodule

bind iterative_dfs_order_unit idfs_checker #(.VERTICES(VERTICES)) u_idfs_checker (.*);
